FILE: src/rpn_pkg.sv
package rpn_pkg;

  localparam int DEF_STACK_DEPTH = 256;
  localparam int DEF_WORD_BITS   = 64;
  localparam int IO_BITS         = 64;
  localparam int IN_DATA_BITS    = 72;
  localparam int OUT_DATA_BITS   = 144;
  localparam int DEPTH_BITS      = 9;

  // host commands
  localparam logic [2:0] CMD_CHAR = 3'd0;
  localparam logic [2:0] CMD_END  = 3'd1;
  localparam logic [2:0] CMD_PUSH = 3'd2;
  localparam logic [2:0] CMD_POP  = 3'd3;
  localparam logic [2:0] CMD_NEW  = 3'd4;

  // error codes
  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_UNDER = 3'd1;
  localparam logic [2:0] ERR_FULL  = 3'd2;
  localparam logic [2:0] ERR_DIV0  = 3'd3;
  localparam logic [2:0] ERR_SHIFT = 3'd4;
  localparam logic [2:0] ERR_BASE  = 3'd5;

  // sequencer phases, shared by controller state and datapath decode
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_FIN  = 4'd1;
  localparam logic [3:0] PH_RA   = 4'd2;
  localparam logic [3:0] PH_RB   = 4'd3;
  localparam logic [3:0] PH_RC   = 4'd4;
  localparam logic [3:0] PH_EX   = 4'd5;
  localparam logic [3:0] PH_DIV  = 4'd6;
  localparam logic [3:0] PH_DQ   = 4'd7;
  localparam logic [3:0] PH_WR   = 4'd8;
  localparam logic [3:0] PH_RT   = 4'd9;
  localparam logic [3:0] PH_OUT  = 4'd10;

  // program characters
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_MOD    = 8'h25;
  localparam logic [7:0] CH_DIVMOD = 8'h7E;
  localparam logic [7:0] CH_AND    = 8'h26;
  localparam logic [7:0] CH_OR     = 8'h7C;
  localparam logic [7:0] CH_XOR    = 8'h5E;
  localparam logic [7:0] CH_LAND   = 8'h4D;
  localparam logic [7:0] CH_LOR    = 8'h6D;
  localparam logic [7:0] CH_LNOT   = 8'h4E;
  localparam logic [7:0] CH_SHL    = 8'h3C;
  localparam logic [7:0] CH_SHR    = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h47;
  localparam logic [7:0] CH_LT     = 8'h28;
  localparam logic [7:0] CH_GT     = 8'h29;
  localparam logic [7:0] CH_LE     = 8'h7B;
  localparam logic [7:0] CH_GE     = 8'h7D;
  localparam logic [7:0] CH_DUP    = 8'h64;
  localparam logic [7:0] CH_SWAP   = 8'h72;
  localparam logic [7:0] CH_ROT    = 8'h74;
  localparam logic [7:0] CH_DROP   = 8'h52;
  localparam logic [7:0] CH_CLR    = 8'h63;
  localparam logic [7:0] CH_DEPTH  = 8'h7A;
  localparam logic [7:0] CH_GETB   = 8'h49;
  localparam logic [7:0] CH_SETB   = 8'h69;
  localparam logic [7:0] CH_NEG    = 8'h5F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_F      = 8'h46;

  localparam logic [4:0] BASE_TEN = 5'd10;
  localparam int         BASE_MIN = 2;
  localparam int         BASE_MAX = 16;

  typedef struct packed {
    logic [3:0] phase;
    logic       accept;
    logic       out_load;
  } rpn_cmd_t;

  typedef struct packed {
    logic fin_only;
    logic div_go;
    logic div_done;
    logic wr_done;
  } rpn_stat_t;

endpackage

FILE: src/rpn_ctrl.sv
module rpn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  rpn_pkg::rpn_stat_t stat,
  output rpn_pkg::rpn_cmd_t  cmd
);

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_load;

  assign in_tready  = (state_r == rpn_pkg::PH_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_load   = (state_r == rpn_pkg::PH_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpn_pkg::PH_IDLE: if (in_tvalid) state_nxt = rpn_pkg::PH_FIN;
      rpn_pkg::PH_FIN:  state_nxt = stat.fin_only ? rpn_pkg::PH_RT : rpn_pkg::PH_RA;
      rpn_pkg::PH_RA:   state_nxt = rpn_pkg::PH_RB;
      rpn_pkg::PH_RB:   state_nxt = rpn_pkg::PH_RC;
      rpn_pkg::PH_RC:   state_nxt = rpn_pkg::PH_EX;
      rpn_pkg::PH_EX:   state_nxt = stat.div_go ? rpn_pkg::PH_DIV : rpn_pkg::PH_WR;
      rpn_pkg::PH_DIV:  if (stat.div_done) state_nxt = rpn_pkg::PH_DQ;
      rpn_pkg::PH_DQ:   state_nxt = rpn_pkg::PH_WR;
      rpn_pkg::PH_WR:   if (stat.wr_done) state_nxt = rpn_pkg::PH_RT;
      rpn_pkg::PH_RT:   state_nxt = rpn_pkg::PH_OUT;
      rpn_pkg::PH_OUT:  if (out_load) state_nxt = rpn_pkg::PH_IDLE;
      default:          state_nxt = rpn_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpn_pkg::PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.phase    = state_r;
  assign cmd.accept   = (state_r == rpn_pkg::PH_IDLE) && in_tvalid;
  assign cmd.out_load = out_load;

endmodule

FILE: src/rpn_dpath.sv
module rpn_dpath #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH,
  parameter int WORD_BITS   = rpn_pkg::DEF_WORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rpn_pkg::rpn_cmd_t                   cmd,
  output rpn_pkg::rpn_stat_t                  stat,
  input  logic [2:0]                          in_cmd,
  input  logic [7:0]                          in_char,
  input  logic [rpn_pkg::IO_BITS-1:0]         in_operand,
  output logic [rpn_pkg::IO_BITS-1:0]         top_value,
  output logic [rpn_pkg::DEPTH_BITS-1:0]      stack_depth,
  output logic [rpn_pkg::IO_BITS-1:0]         popped_value,
  output logic                                popped_valid,
  output logic [2:0]                          error_code
);

  localparam int W   = WORD_BITS;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int SW  = $clog2(WORD_BITS);
  localparam int DCW = $clog2(WORD_BITS + 1);

  logic [W-1:0] mem [STACK_DEPTH];
  logic [W-1:0] rdata_r;

  logic [2:0]    cmd_r;
  logic [7:0]    ch_r;
  logic [W-1:0]  opv_r;
  logic [CW-1:0] cnt_r;
  logic [4:0]    base_r;
  logic          act_r, neg_r;
  logic [W-1:0]  acc_r;
  logic [2:0]    err_r;
  logic [W-1:0]  a_r, b_r;
  logic [W-1:0]  pop_r;
  logic          pv_r;

  logic [AW-1:0] wa_r [3];
  logic [W-1:0]  wd_r [3];
  logic [1:0]    wn_r, wi_r;

  logic [W-1:0]   dq_r, rem_r, dd_r;
  logic [DCW-1:0] dcnt_r;
  logic           sa_r, sb_r;

  logic [W-1:0]  top_r, popo_r;
  logic [CW-1:0] depo_r;
  logic          pvo_r;
  logic [2:0]    erro_r;

  // phase decode
  logic ph_fin, ph_rb, ph_rc, ph_ex, ph_div, ph_dq, ph_wr;
  assign ph_fin = (cmd.phase == rpn_pkg::PH_FIN);
  assign ph_rb  = (cmd.phase == rpn_pkg::PH_RB);
  assign ph_rc  = (cmd.phase == rpn_pkg::PH_RC);
  assign ph_ex  = (cmd.phase == rpn_pkg::PH_EX);
  assign ph_div = (cmd.phase == rpn_pkg::PH_DIV);
  assign ph_dq  = (cmd.phase == rpn_pkg::PH_DQ);
  assign ph_wr  = (cmd.phase == rpn_pkg::PH_WR);

  // stack addresses relative to the count
  logic [AW-1:0] a_n, a_m1, a_m2, a_m3;
  assign a_n  = AW'(cnt_r);
  assign a_m1 = AW'(cnt_r - CW'(1));
  assign a_m2 = AW'(cnt_r - CW'(2));
  assign a_m3 = AW'(cnt_r - CW'(3));

  logic full, lt1, lt2, lt3;
  assign full = (cnt_r >= CW'(STACK_DEPTH));
  assign lt1  = (cnt_r < CW'(1));
  assign lt2  = (cnt_r < CW'(2));
  assign lt3  = (cnt_r < CW'(3));

  // digit decode
  logic       is_dec, is_hex, is_neg, is_digit, is_num;
  logic [3:0] dval;
  assign is_dec   = (ch_r >= rpn_pkg::CH_0) && (ch_r <= rpn_pkg::CH_9);
  assign is_hex   = (ch_r >= rpn_pkg::CH_A) && (ch_r <= rpn_pkg::CH_F);
  assign is_neg   = (ch_r == rpn_pkg::CH_NEG);
  assign is_digit = is_dec || is_hex;
  assign is_num   = (cmd_r == rpn_pkg::CMD_CHAR) && (is_digit || is_neg);
  assign dval     = is_dec ? 4'(ch_r - rpn_pkg::CH_0) : 4'(ch_r - rpn_pkg::CH_A + 8'd10);

  logic [W-1:0] acc_base, acc_mul, num_val;
  logic         neg_base;
  assign acc_base = act_r ? acc_r : '0;
  assign neg_base = act_r ? neg_r : 1'b0;
  assign acc_mul  = acc_base * W'(base_r) + W'(dval);
  assign num_val  = neg_r ? (~acc_r + W'(1)) : acc_r;

  // a pending number is pushed on each non-number command up to pop
  logic fin_push;
  assign fin_push = ph_fin && !is_num && (cmd_r <= rpn_pkg::CMD_POP) && act_r && !full;

  assign stat.fin_only = is_num || (cmd_r == rpn_pkg::CMD_END) || (cmd_r >= rpn_pkg::CMD_NEW);

  // execute decode
  logic [W-1:0]  c_w;
  logic [2:0]    e2;
  logic [1:0]    wn;
  logic [AW-1:0] wa [3];
  logic [W-1:0]  wd [3];
  logic [CW-1:0] cnt_new;
  logic [4:0]    base_new;
  logic          div_go, pop_go;
  logic [W-1:0]  r;
  logic          lt_ab, lt_ba;
  logic          is_mul;

  assign c_w    = rdata_r;
  assign lt_ab  = ($signed(a_r) < $signed(b_r));
  assign lt_ba  = ($signed(b_r) < $signed(a_r));
  assign is_mul = (ch_r == rpn_pkg::CH_MUL);

  always_comb begin
    case (ch_r)
      rpn_pkg::CH_ADD:  r = b_r + a_r;
      rpn_pkg::CH_SUB:  r = b_r - a_r;
      rpn_pkg::CH_AND:  r = b_r & a_r;
      rpn_pkg::CH_OR:   r = b_r | a_r;
      rpn_pkg::CH_XOR:  r = b_r ^ a_r;
      rpn_pkg::CH_LAND: r = W'((a_r != '0) && (b_r != '0));
      rpn_pkg::CH_LOR:  r = W'((a_r != '0) || (b_r != '0));
      rpn_pkg::CH_EQ:   r = W'(a_r == b_r);
      rpn_pkg::CH_LT:   r = W'(lt_ab);
      rpn_pkg::CH_GT:   r = W'(lt_ba);
      rpn_pkg::CH_LE:   r = W'(!lt_ba);
      rpn_pkg::CH_GE:   r = W'(!lt_ab);
      rpn_pkg::CH_SHL:  r = b_r << a_r[SW-1:0];
      rpn_pkg::CH_SHR:  r = W'($signed(b_r) >>> a_r[SW-1:0]);
      default:          r = '0;
    endcase
  end

  always_comb begin
    e2       = rpn_pkg::ERR_OK;
    wn       = 2'd0;
    wa[0]    = a_m2;
    wa[1]    = a_m1;
    wa[2]    = a_m3;
    wd[0]    = r;
    wd[1]    = '0;
    wd[2]    = '0;
    cnt_new  = cnt_r;
    base_new = base_r;
    div_go   = 1'b0;
    pop_go   = 1'b0;
    case (cmd_r)
      rpn_pkg::CMD_CHAR: begin
        case (ch_r)
          rpn_pkg::CH_ADD, rpn_pkg::CH_SUB, rpn_pkg::CH_AND, rpn_pkg::CH_OR,
          rpn_pkg::CH_XOR, rpn_pkg::CH_LAND, rpn_pkg::CH_LOR, rpn_pkg::CH_EQ,
          rpn_pkg::CH_LT, rpn_pkg::CH_GT, rpn_pkg::CH_LE, rpn_pkg::CH_GE: begin
            if (lt2) begin
              e2 = rpn_pkg::ERR_UNDER;
            end else begin
              wn = 2'd1;
              cnt_new = cnt_r - CW'(1);
            end
          end
          rpn_pkg::CH_SHL, rpn_pkg::CH_SHR: begin
            if (lt2) begin
              e2 = rpn_pkg::ERR_UNDER;
            end else if (a_r >= W'(W)) begin
              e2 = rpn_pkg::ERR_SHIFT;
            end else begin
              wn = 2'd1;
              cnt_new = cnt_r - CW'(1);
            end
          end
          rpn_pkg::CH_MUL: begin
            if (lt2) e2 = rpn_pkg::ERR_UNDER;
            else div_go = 1'b1;
          end
          rpn_pkg::CH_DIV, rpn_pkg::CH_MOD, rpn_pkg::CH_DIVMOD: begin
            if (lt2) begin
              e2 = rpn_pkg::ERR_UNDER;
            end else if (a_r == '0) begin
              e2 = rpn_pkg::ERR_DIV0;
            end else begin
              div_go = 1'b1;
            end
          end
          rpn_pkg::CH_LNOT: begin
            if (lt1) begin
              e2 = rpn_pkg::ERR_UNDER;
            end else begin
              wn = 2'd1;
              wa[0] = a_m1;
              wd[0] = W'(a_r == '0);
            end
          end
          rpn_pkg::CH_DROP: begin
            if (lt1) e2 = rpn_pkg::ERR_UNDER;
            else cnt_new = cnt_r - CW'(1);
          end
          rpn_pkg::CH_DUP, rpn_pkg::CH_DEPTH, rpn_pkg::CH_GETB: begin
            if (ch_r == rpn_pkg::CH_DUP && lt1) begin
              e2 = rpn_pkg::ERR_UNDER;
            end else if (full) begin
              e2 = rpn_pkg::ERR_FULL;
            end else begin
              wn = 2'd1;
              wa[0] = a_n;
              cnt_new = cnt_r + CW'(1);
              if (ch_r == rpn_pkg::CH_DUP) wd[0] = a_r;
              else if (ch_r == rpn_pkg::CH_DEPTH) wd[0] = W'(cnt_r);
              else wd[0] = W'(base_r);
            end
          end
          rpn_pkg::CH_SWAP: begin
            if (lt2) begin
              e2 = rpn_pkg::ERR_UNDER;
            end else begin
              wn = 2'd2;
              wd[0] = a_r;
              wd[1] = b_r;
            end
          end
          rpn_pkg::CH_ROT: begin
            if (lt3) begin
              e2 = rpn_pkg::ERR_UNDER;
            end else begin
              wn = 2'd3;
              wd[0] = a_r;
              wd[1] = c_w;
              wd[2] = b_r;
            end
          end
          rpn_pkg::CH_CLR: cnt_new = '0;
          rpn_pkg::CH_SETB: begin
            if (lt1) begin
              e2 = rpn_pkg::ERR_UNDER;
            end else if ($signed(a_r) < $signed(W'(rpn_pkg::BASE_MIN)) ||
                         $signed(a_r) > $signed(W'(rpn_pkg::BASE_MAX))) begin
              e2 = rpn_pkg::ERR_BASE;
            end else begin
              base_new = a_r[4:0];
              cnt_new = cnt_r - CW'(1);
            end
          end
          default: ;
        endcase
      end
      rpn_pkg::CMD_PUSH: begin
        if (full) begin
          e2 = rpn_pkg::ERR_FULL;
        end else begin
          wn = 2'd1;
          wa[0] = a_n;
          wd[0] = opv_r;
          cnt_new = cnt_r + CW'(1);
        end
      end
      rpn_pkg::CMD_POP: begin
        if (lt1) begin
          e2 = rpn_pkg::ERR_UNDER;
        end else begin
          pop_go = 1'b1;
          cnt_new = cnt_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign stat.div_go = div_go;

  // iterative unit, one bit per cycle: restoring divide on magnitudes,
  // or shift-and-add multiply (product wraps at W bits)
  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + W'(1)) : v;
  endfunction

  logic [W:0]   dtrial;
  logic         dfit;
  assign dtrial = {rem_r, dq_r[W-1]};
  assign dfit   = (dtrial >= {1'b0, dd_r});
  assign stat.div_done = (dcnt_r == DCW'(W - 1));

  logic [W-1:0] q_s, m_s;
  assign q_s = (sa_r != sb_r) ? (~dq_r + W'(1)) : dq_r;
  assign m_s = sb_r ? (~rem_r + W'(1)) : rem_r;

  logic [2:0] wi_ext, wn_ext;
  assign wi_ext = {1'b0, wi_r} + 3'd1;
  assign wn_ext = {1'b0, wn_r};
  assign stat.wr_done = (wi_ext >= wn_ext);

  // memory ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [W-1:0]  wdata;
  always_comb begin
    we    = 1'b0;
    waddr = a_n;
    wdata = num_val;
    if (fin_push) begin
      we = 1'b1;
    end else if (ph_wr && (wi_r < wn_r)) begin
      we    = 1'b1;
      waddr = wa_r[wi_r];
      wdata = wd_r[wi_r];
    end
  end

  always_comb begin
    raddr = a_m1;
    if (ph_rb) raddr = a_m2;
    else if (ph_rc) raddr = a_m3;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // item and execute registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_cmd;
      ch_r  <= in_char;
      opv_r <= W'(in_operand);
    end
    if (ph_rb) a_r <= rdata_r;
    if (ph_rc) b_r <= rdata_r;
    if (ph_ex) begin
      wi_r  <= 2'd0;
      wa_r  <= wa;
      wd_r  <= wd;
      pop_r <= a_r;
      sa_r  <= a_r[W-1];
      sb_r  <= b_r[W-1];
      dq_r  <= is_mul ? a_r : mag(b_r);
      dd_r  <= is_mul ? b_r : mag(a_r);
      rem_r <= '0;
      dcnt_r <= '0;
    end
    if (ph_div) begin
      if (is_mul) begin
        rem_r <= dq_r[0] ? (rem_r + dd_r) : rem_r;
        dq_r  <= {1'b0, dq_r[W-1:1]};
        dd_r  <= {dd_r[W-2:0], 1'b0};
      end else begin
        rem_r <= dfit ? W'(dtrial - {1'b0, dd_r}) : dtrial[W-1:0];
        dq_r  <= {dq_r[W-2:0], dfit};
      end
      dcnt_r <= dcnt_r + DCW'(1);
    end
    if (ph_dq) begin
      wi_r  <= 2'd0;
      wa_r[0] <= a_m2;
      wa_r[1] <= a_m1;
      wd_r[0] <= is_mul ? rem_r : ((ch_r == rpn_pkg::CH_MOD) ? m_s : q_s);
      wd_r[1] <= m_s;
    end
    if (ph_wr) wi_r <= wi_r + 2'd1;
    if (cmd.out_load) begin
      top_r  <= (cnt_r == '0) ? '0 : rdata_r;
      depo_r <= cnt_r;
      popo_r <= pv_r ? pop_r : '0;
      pvo_r  <= pv_r;
      erro_r <= err_r;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      base_r <= rpn_pkg::BASE_TEN;
      act_r  <= 1'b0;
      neg_r  <= 1'b0;
      acc_r  <= '0;
      err_r  <= rpn_pkg::ERR_OK;
      pv_r   <= 1'b0;
      wn_r   <= 2'd0;
    end else begin
      if (cmd.accept) begin
        err_r <= rpn_pkg::ERR_OK;
        pv_r  <= 1'b0;
      end
      if (ph_fin) begin
        if (cmd_r == rpn_pkg::CMD_NEW) begin
          cnt_r  <= '0;
          base_r <= rpn_pkg::BASE_TEN;
          act_r  <= 1'b0;
          neg_r  <= 1'b0;
          acc_r  <= '0;
        end else if (is_num) begin
          act_r <= 1'b1;
          neg_r <= neg_base || is_neg;
          acc_r <= is_digit ? acc_mul : acc_base;
        end else if (cmd_r <= rpn_pkg::CMD_POP && act_r) begin
          act_r <= 1'b0;
          if (full) err_r <= rpn_pkg::ERR_FULL;
          else cnt_r <= cnt_r + CW'(1);
        end
      end
      if (ph_ex) begin
        if (err_r == rpn_pkg::ERR_OK) err_r <= e2;
        if (e2 == rpn_pkg::ERR_OK) begin
          wn_r   <= wn;
          cnt_r  <= cnt_new;
          base_r <= base_new;
          pv_r   <= pop_go;
        end else begin
          wn_r <= 2'd0;
        end
      end
      if (ph_dq) begin
        if (ch_r == rpn_pkg::CH_DIVMOD) begin
          wn_r <= 2'd2;
        end else begin
          wn_r  <= 2'd1;
          cnt_r <= cnt_r - CW'(1);
        end
      end
    end
  end

  assign top_value    = rpn_pkg::IO_BITS'($signed(top_r));
  assign stack_depth  = rpn_pkg::DEPTH_BITS'(depo_r);
  assign popped_value = rpn_pkg::IO_BITS'($signed(popo_r));
  assign popped_valid = pvo_r;
  assign error_code   = erro_r;

endmodule

FILE: src/rpn_stack_calculator.sv
// RPN stack calculator, fed one program character or host command per transfer.
// Input channel: in_tuser carries the command (char, end, push, pop, new
// program), in_tdata the character byte and the operand word. Every accepted
// input transfer yields exactly one result transfer on the out_ channel with
// the top of stack, depth, popped word and error code.
// Sequencing: digits, end of program and new program go through the finish and
// result steps only; stack operations read the top three words from the stack
// RAM one per cycle and write back up to three. Multiply runs a
// shift-and-add loop and divide and modulo a restoring divider, one bit per
// cycle; that loop makes them the slowest items. The next input transfer is
// taken in the cycle after the result is loaded.
// One item is in work at a time; in_tready is high while the sequencer is idle.
// The result sits in an output register, so the next item is taken while a
// result still waits; a stalled receiver holds out_tdata stable and the next
// result waits for that register to drain.
// Reset (rst_n low, synchronous) empties the stack, sets the base to ten and
// drops any pending number; the stack RAM itself is not cleared.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH,
  parameter int WORD_BITS   = rpn_pkg::DEF_WORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rpn_pkg::IN_DATA_BITS-1:0]  in_tdata,   // char_code, operand_value
  input  logic [2:0]                        in_tuser,   // cmd
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // top_value, stack_depth, popped_value, error_code, 4 zero bits
  output logic [rpn_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic                              out_tuser   // popped_valid
);

  rpn_pkg::rpn_cmd_t  cmd;
  rpn_pkg::rpn_stat_t stat;

  logic [rpn_pkg::IO_BITS-1:0]    top_value, popped_value;
  logic [rpn_pkg::DEPTH_BITS-1:0] stack_depth;
  logic [2:0]                     error_code;
  logic                           popped_valid;

  rpn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_BITS   (WORD_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_cmd       (in_tuser),
    .in_char      (in_tdata[7:0]),
    .in_operand   (in_tdata[71:8]),
    .top_value    (top_value),
    .stack_depth  (stack_depth),
    .popped_value (popped_value),
    .popped_valid (popped_valid),
    .error_code   (error_code)
  );

  assign out_tdata = {4'b0000, error_code, popped_value, stack_depth, top_value};
  assign out_tuser = popped_valid;

endmodule
